// File: sv/qta_pkg.sv
// Package for the quadtree tile allocator: node codes, status codes, sizes, operations, FSM states.
// No dependencies.
package qta_pkg;
	localparam int ATLAS_TEXELS_DEF = 8192;
	localparam int TREE_LEVELS_DEF = 5;
	localparam int HW = 11;
	localparam int CW = 13;
	localparam int LW = 3;
	localparam int SW = 2;

	typedef enum logic [1:0] {
		NS_ABSENT = 2'd0,
		NS_FREE = 2'd1,
		NS_OCC = 2'd2,
		NS_SPLIT = 2'd3
	} node_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_NOSPACE = 2'd1,
		ST_BADHANDLE = 2'd2
	} status_t;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE = 1'b1;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_POP, S_RD, S_EVAL, S_WKID, S_FRD, S_FCHK,
		S_MRD, S_MCHK, S_MCLR, S_DONE
	} fsm_t;

	typedef struct packed {
		logic we;
		logic [HW-1:0] waddr;
		node_t wdata;
		logic [HW-1:0] raddr;
	} mem_req_t;
endpackage

// File: sv/qta_if.sv
// Valid/ready channel interface carrying one word of payload.
// Depends on nothing; payload type is a parameter.
interface qta_if #(parameter type T = logic) (input logic clk);
	logic valid;
	logic ready;
	T data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// File: sv/qta_node_mem.sv
// Node state memory: one write port and one registered read port.
// Depends on qta_pkg.
module qta_node_mem #(
	parameter int DEPTH = 1365
) (
	input logic clk,
	input qta_pkg::mem_req_t req,
	output qta_pkg::node_t rdata
);
	qta_pkg::node_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (req.we && 32'(req.waddr) < DEPTH)
			mem[req.waddr] <= req.wdata;
		if (32'(req.raddr) < DEPTH)
			rdata <= mem[req.raddr];
		else
			rdata <= qta_pkg::NS_ABSENT;
	end
endmodule

// File: sv/qta_coords.sv
// Converts a node handle and its level to texel coordinates, one digit per cycle.
// Depends on qta_pkg.
module qta_coords #(
	parameter int ATLAS_TEXELS = qta_pkg::ATLAS_TEXELS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [qta_pkg::HW-1:0] node,
	input logic [3:0] level,
	output logic busy,
	output logic [qta_pkg::CW-1:0] x,
	output logic [qta_pkg::CW-1:0] y
);
	localparam int AW = $clog2(ATLAS_TEXELS) + 2;
	logic [qta_pkg::HW-1:0] n_q;
	logic [AW-1:0] half_q, cx_q, cy_q;
	logic [qta_pkg::HW-1:0] m;
	logic [1:0] c;

	assign m = n_q - qta_pkg::HW'(1);
	assign c = m[1:0];
	assign busy = (n_q != '0);
	assign x = cx_q[qta_pkg::CW-1:0];
	assign y = cy_q[qta_pkg::CW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= '0;
		end else if (start) begin
			n_q <= node;
		end else if (busy) begin
			n_q <= m >> 2;
		end
	end

	// Walk from the node toward the root; the half size starts at the node's own
	// size and doubles each step.
	always_ff @(posedge clk) begin
		if (start) begin
			half_q <= AW'(ATLAS_TEXELS) >> level;
			cx_q <= '0;
			cy_q <= '0;
		end else if (busy) begin
			if (c[0]) cx_q <= cx_q + half_q;
			if (c[1]) cy_q <= cy_q + half_q;
			half_q <= half_q << 1;
		end
	end
endmodule

// File: sv/quadtree_tile_allocator_unit.sv
// Top level of the quadtree tile allocator: sequencer, walk stack, node memory, coordinate unit.
// Depends on qta_pkg, qta_if, qta_node_mem and qta_coords.
//
// channel  direction  payload
// req      sink       op, size_level, handle
// rsp      source     status, tile_handle, tile_x, tile_y
//
// An allocate reads each node it visits; it splits each free node it descends into,
// writing its children, and pushes those children on the walk stack. A placed tile then
// gets its coordinates one tree level at a time. A free checks the handle, then reads the
// children of each parent in turn and clears them on a merge, all through the single node
// memory port. After reset a clearing pass writes every node before req.ready rises.
// A result waits in the output register while the next word is processed; the next
// result is held back until the waiting one is taken.
module quadtree_tile_allocator_unit #(
	parameter int ATLAS_TEXELS = qta_pkg::ATLAS_TEXELS_DEF,
	parameter int TREE_LEVELS = qta_pkg::TREE_LEVELS_DEF
) (
	input logic clk,
	input logic arst_n,
	qta_if.sink req,
	qta_if.source rsp
);
	localparam int NODE_COUNT = ((1 << (2 * (TREE_LEVELS + 1))) - 1) / 3;
	localparam int STACK_DEPTH = 3 * TREE_LEVELS + 1;
	localparam int DW = $clog2(STACK_DEPTH + 1);
	localparam int PW = $clog2(STACK_DEPTH);
	localparam int HW = qta_pkg::HW;

	qta_pkg::fsm_t state_q, state_d;
	qta_pkg::mem_req_t mreq;
	qta_pkg::node_t rdata;
	logic [HW-1:0] stack_q [STACK_DEPTH];
	logic [DW-1:0] depth_q;
	logic [HW-1:0] cur_q, clr_q;
	logic [2:0] want_q;
	logic [2:0] kid_q;
	logic [3:0] cur_lv_q;
	logic [1:0] status_q;
	logic op_q;
	logic [HW-1:0] par_q;
	logic all_free_q;
	logic [HW-1:0] tile_q;
	logic out_valid_q;
	logic [1:0] st_out_q;
	logic [HW-1:0] h_out_q;
	logic [qta_pkg::CW-1:0] x_out_q, y_out_q;
	logic cstart, cbusy, done_fire;
	logic [qta_pkg::CW-1:0] cx, cy;
	logic [HW-1:0] top, sib_addr;
	logic [HW+1:0] kid_base;
	logic leafy;

	function automatic logic [3:0] level4(input logic [HW-1:0] h);
		logic [3:0] l;
		int t;
		l = '0;
		t = 1;
		for (int k = 0; k < TREE_LEVELS; k++) begin
			if (32'(h) >= t) l = l + 4'd1;
			t = 4 * t + 1;
		end
		return l;
	endfunction

	qta_node_mem #(.DEPTH(NODE_COUNT)) u_mem (.clk(clk), .req(mreq), .rdata(rdata));
	qta_coords #(.ATLAS_TEXELS(ATLAS_TEXELS)) u_coords (
		.clk(clk), .arst_n(arst_n), .start(cstart), .node(cur_q), .level(cur_lv_q),
		.busy(cbusy), .x(cx), .y(cy)
	);

	assign top = stack_q[PW'(depth_q - DW'(1))];
	assign kid_base = {cur_q, 2'b00};
	assign sib_addr = HW'({par_q, 2'b00}) + HW'(kid_q) + HW'(1);
	assign leafy = (32'(kid_base) + 4 >= NODE_COUNT);
	assign req.ready = (state_q == qta_pkg::S_IDLE);
	assign rsp.valid = out_valid_q;
	assign rsp.data = {st_out_q, h_out_q, x_out_q, y_out_q};
	assign cstart = (state_q == qta_pkg::S_EVAL) && (rdata == qta_pkg::NS_FREE)
		&& (32'(cur_lv_q) == 32'(want_q));
	assign done_fire = (state_q == qta_pkg::S_DONE) && !cbusy && !out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			qta_pkg::S_CLEAR:
				if (32'(clr_q) == NODE_COUNT - 1) state_d = qta_pkg::S_IDLE;
			qta_pkg::S_IDLE:
				if (req.valid && req.ready)
					state_d = (req.data.op == qta_pkg::OP_ALLOC) ? qta_pkg::S_POP
						: qta_pkg::S_FRD;
			qta_pkg::S_POP:
				state_d = (depth_q == '0) ? qta_pkg::S_DONE : qta_pkg::S_RD;
			qta_pkg::S_RD: state_d = qta_pkg::S_EVAL;
			qta_pkg::S_EVAL: begin
				if (rdata == qta_pkg::NS_ABSENT || rdata == qta_pkg::NS_OCC
					|| 32'(cur_lv_q) > 32'(want_q))
					state_d = qta_pkg::S_POP;
				else if (cstart) state_d = qta_pkg::S_DONE;
				else if (leafy) state_d = qta_pkg::S_POP;
				else state_d = qta_pkg::S_WKID;
			end
			qta_pkg::S_WKID: if (kid_q == 3'd4) state_d = qta_pkg::S_POP;
			qta_pkg::S_FRD: state_d = qta_pkg::S_FCHK;
			qta_pkg::S_FCHK:
				state_d = (rdata == qta_pkg::NS_OCC && 32'(cur_q) < NODE_COUNT
					&& cur_q != '0) ? qta_pkg::S_MRD : qta_pkg::S_DONE;
			qta_pkg::S_MRD: state_d = qta_pkg::S_MCHK;
			qta_pkg::S_MCHK:
				if (kid_q != 3'd3) state_d = qta_pkg::S_MRD;
				else if (all_free_q && rdata == qta_pkg::NS_FREE) state_d = qta_pkg::S_MCLR;
				else state_d = qta_pkg::S_DONE;
			qta_pkg::S_MCLR:
				if (kid_q == 3'd4)
					state_d = (par_q == '0) ? qta_pkg::S_DONE : qta_pkg::S_MRD;
			qta_pkg::S_DONE:
				state_d = (cbusy || out_valid_q) ? qta_pkg::S_DONE : qta_pkg::S_IDLE;
			default: state_d = qta_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		mreq = '{we: 1'b0, waddr: cur_q, wdata: qta_pkg::NS_ABSENT, raddr: cur_q};
		unique case (state_q)
			qta_pkg::S_CLEAR: begin
				mreq.we = 1'b1;
				mreq.waddr = clr_q;
				mreq.wdata = (clr_q == '0) ? qta_pkg::NS_FREE : qta_pkg::NS_ABSENT;
			end
			qta_pkg::S_EVAL: begin
				mreq.we = (rdata == qta_pkg::NS_FREE) && (cstart || (!leafy
					&& 32'(cur_lv_q) <= 32'(want_q)));
				mreq.wdata = cstart ? qta_pkg::NS_OCC : qta_pkg::NS_SPLIT;
			end
			qta_pkg::S_WKID: begin
				mreq.we = (kid_q != 3'd0) && all_free_q;
				mreq.waddr = HW'(kid_base) + HW'(kid_q);
				mreq.wdata = qta_pkg::NS_FREE;
			end
			qta_pkg::S_FCHK: begin
				mreq.we = (rdata == qta_pkg::NS_OCC) && (32'(cur_q) < NODE_COUNT);
				mreq.wdata = qta_pkg::NS_FREE;
			end
			qta_pkg::S_MRD: mreq.raddr = sib_addr;
			qta_pkg::S_MCLR: begin
				// The four children are cleared first, then the parent becomes a free leaf.
				mreq.we = 1'b1;
				mreq.waddr = (kid_q == 3'd4) ? par_q : sib_addr;
				mreq.wdata = (kid_q == 3'd4) ? qta_pkg::NS_FREE : qta_pkg::NS_ABSENT;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= qta_pkg::S_CLEAR;
			clr_q <= '0;
			depth_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == qta_pkg::S_CLEAR) clr_q <= clr_q + HW'(1);
			if (done_fire) out_valid_q <= 1'b1;
			else if (rsp.valid && rsp.ready) out_valid_q <= 1'b0;
			if (state_q == qta_pkg::S_IDLE && req.valid && req.ready
				&& req.data.op == qta_pkg::OP_ALLOC)
				depth_q <= DW'(1);
			if (state_q == qta_pkg::S_POP && depth_q != '0) depth_q <= depth_q - DW'(1);
			if (state_q == qta_pkg::S_WKID && kid_q != 3'd0 && 32'(depth_q) < STACK_DEPTH)
				depth_q <= depth_q + DW'(1);
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			qta_pkg::S_IDLE: begin
				op_q <= req.data.op;
				want_q <= req.data.size_level;
				cur_q <= req.data.handle;
				stack_q[0] <= '0;
				status_q <= (req.data.op == qta_pkg::OP_ALLOC) ? qta_pkg::ST_NOSPACE
					: qta_pkg::ST_BADHANDLE;
				tile_q <= '0;
			end
			qta_pkg::S_POP: begin
				if (depth_q != '0) cur_q <= top;
			end
			qta_pkg::S_RD: begin
				// Level of the popped node from its index.
				cur_lv_q <= level4(cur_q);
			end
			qta_pkg::S_EVAL: begin
				kid_q <= 3'd0;
				all_free_q <= (rdata == qta_pkg::NS_FREE);
				if (cstart) begin
					status_q <= qta_pkg::ST_OK;
					tile_q <= cur_q;
				end
			end
			qta_pkg::S_WKID: begin
				kid_q <= kid_q + 3'd1;
				if (kid_q != 3'd0 && 32'(depth_q) < STACK_DEPTH)
					stack_q[PW'(depth_q)] <= HW'(kid_base) + HW'(kid_q);
			end
			qta_pkg::S_FCHK: begin
				if (rdata == qta_pkg::NS_OCC && 32'(cur_q) < NODE_COUNT)
					status_q <= qta_pkg::ST_OK;
				par_q <= (cur_q - HW'(1)) >> 2;
				kid_q <= 3'd0;
				all_free_q <= 1'b1;
			end
			qta_pkg::S_MCHK: begin
				if (rdata != qta_pkg::NS_FREE) all_free_q <= 1'b0;
				kid_q <= (kid_q == 3'd3) ? 3'd0 : kid_q + 3'd1;
			end
			qta_pkg::S_MCLR: begin
				if (kid_q == 3'd4) begin
					kid_q <= 3'd0;
					all_free_q <= 1'b1;
					cur_q <= par_q;
					par_q <= (par_q - HW'(1)) >> 2;
				end else begin
					kid_q <= kid_q + 3'd1;
				end
			end
			qta_pkg::S_DONE: begin
				if (done_fire) begin
					st_out_q <= status_q;
					h_out_q <= tile_q;
					x_out_q <= (status_q == qta_pkg::ST_OK && op_q == qta_pkg::OP_ALLOC)
						? cx : '0;
					y_out_q <= (status_q == qta_pkg::ST_OK && op_q == qta_pkg::OP_ALLOC)
						? cy : '0;
				end
			end
			default: ;
		endcase
	end
endmodule

// File: sv/qta_checker.sv
// Port-level checker for the quadtree tile allocator, bound to the top level.
// Depends on qta_pkg and quadtree_tile_allocator_unit.
module qta_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [1:0] out_status,
	input logic [10:0] out_handle
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_handle))
		else $error("result word dropped while stalled");
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_status != 2'd3)
		else $error("undefined status");
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_status != qta_pkg::ST_OK |-> out_handle == '0)
		else $error("failed request returned a handle");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second word taken while busy");
endmodule

bind quadtree_tile_allocator_unit qta_checker u_qta_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(req.valid), .in_ready(req.ready),
	.out_valid(rsp.valid), .out_ready(rsp.ready), .out_status(rsp.data[38:37]),
	.out_handle(rsp.data[36:26])
);

// File: sim/qta_tb_pkg.sv
// Word types for the allocator's request and response channels, used by the testbench.
// Depends on qta_pkg.
package qta_tb_pkg;
	import qta_pkg::*;

	typedef struct packed {
		logic op;
		logic [LW-1:0] size_level;
		logic [HW-1:0] handle;
	} req_word_t;

	typedef struct packed {
		status_t status;
		logic [HW-1:0] tile_handle;
		logic [CW-1:0] tile_x;
		logic [CW-1:0] tile_y;
	} rsp_word_t;
endpackage

// File: sim/qta_alloc_checker.sv
// Checker for the quadtree tile allocator: mirrors the node tree, predicts each response word
// and compares it with the block's output. Depends on qta_pkg and qta_tb_pkg.
module qta_alloc_checker
	import qta_pkg::*;
	import qta_tb_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input req_word_t req_data,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_word_t rsp_data,
	output int fail_count,
	output int pending
);
	localparam int NODES = 1365;
	localparam int WALK_MAX = 16;

	node_t tree[NODES];
	rsp_word_t expected_q[$];

	function automatic int depth_of(int n);
		int lv;
		lv = 0;
		while (n != 0) begin
			n = (n - 1) >> 2;
			lv++;
		end
		return lv;
	endfunction

	function automatic rsp_word_t place_tile(int want);
		rsp_word_t r;
		int stk[$];
		int n, lv, cx, cy, m, half;
		r = '0;
		r.status = ST_NOSPACE;
		stk.insert(stk.size(), 0);
		while (stk.size() != 0) begin
			n = stk[stk.size() - 1];
			stk.delete(stk.size() - 1);
			lv = depth_of(n);
			if (tree[n] == NS_ABSENT || tree[n] == NS_OCC || lv > want)
				continue;
			if (tree[n] == NS_FREE && lv == want) begin
				tree[n] = NS_OCC;
				cx = 0;
				cy = 0;
				m = n;
				while (m != 0) begin
					half = 8192 >> lv;
					if (((m - 1) & 1) != 0)
						cx += half;
					if (((m - 1) & 2) != 0)
						cy += half;
					m = (m - 1) >> 2;
					lv--;
				end
				r.status = ST_OK;
				r.tile_handle = HW'(n);
				r.tile_x = CW'(cx);
				r.tile_y = CW'(cy);
				return r;
			end
			if (4 * n + 4 >= NODES)
				continue;
			if (tree[n] == NS_FREE) begin
				tree[n] = NS_SPLIT;
				for (int k = 1; k <= 4; k++)
					tree[4 * n + k] = NS_FREE;
			end
			for (int k = 1; k <= 4; k++)
				if (stk.size() < WALK_MAX)
					stk.insert(stk.size(), 4 * n + k);
		end
		return r;
	endfunction

	function automatic rsp_word_t release_tile(int h);
		rsp_word_t r;
		int p;
		bit all_free;
		r = '0;
		if (h >= NODES || tree[h] != NS_OCC) begin
			r.status = ST_BADHANDLE;
			return r;
		end
		r.status = ST_OK;
		tree[h] = NS_FREE;
		while (h != 0) begin
			p = (h - 1) >> 2;
			all_free = 1;
			for (int k = 1; k <= 4; k++)
				if (tree[4 * p + k] != NS_FREE)
					all_free = 0;
			if (!all_free)
				break;
			for (int k = 1; k <= 4; k++)
				tree[4 * p + k] = NS_ABSENT;
			tree[p] = NS_FREE;
			h = p;
		end
		return r;
	endfunction

	always @(posedge clk) begin
		rsp_word_t exp_w;
		if (!arst_n) begin
			for (int i = 0; i < NODES; i++)
				tree[i] = NS_ABSENT;
			tree[0] = NS_FREE;
			expected_q.delete();
		end else begin
			if (req_valid && req_ready) begin
				if (req_data.op == OP_ALLOC)
					expected_q.insert(expected_q.size(),
						place_tile(int'(req_data.size_level)));
				else
					expected_q.insert(expected_q.size(), release_tile(int'(req_data.handle)));
			end
			if (rsp_valid && rsp_ready) begin
				if (expected_q.size() == 0) begin
					$error("Response word arrived with nothing expected.");
					fail_count++;
				end else begin
					exp_w = expected_q.pop_front();
					if (rsp_data.status !== exp_w.status) begin
						$error("status: expected %0d, got %0d", exp_w.status, rsp_data.status);
						fail_count++;
					end
					if (rsp_data.tile_handle !== exp_w.tile_handle) begin
						$error("tile_handle: expected %0d, got %0d", exp_w.tile_handle,
							rsp_data.tile_handle);
						fail_count++;
					end
					if (rsp_data.tile_x !== exp_w.tile_x) begin
						$error("tile_x: expected %0d, got %0d", exp_w.tile_x, rsp_data.tile_x);
						fail_count++;
					end
					if (rsp_data.tile_y !== exp_w.tile_y) begin
						$error("tile_y: expected %0d, got %0d", exp_w.tile_y, rsp_data.tile_y);
						fail_count++;
					end
				end
			end
		end
		pending = expected_q.size();
	end
endmodule

// File: sim/tb_quadtree_tile_allocator_unit.sv
// Testbench top for the quadtree tile allocator: clock, reset, request stimulus and stalls.
// Depends on qta_pkg, qta_tb_pkg, qta_if, qta_alloc_checker and the allocator RTL.
module tb_quadtree_tile_allocator_unit;
	import qta_pkg::*;
	import qta_tb_pkg::*;

	localparam longint CYCLE_LIMIT = 60000000;

	logic clk = 1'b0;
	logic arst_n;
	int fail_count;
	int pending;
	longint cycles;
	int n_alloc, n_free, n_ok_alloc;
	bit stall_on;
	int rsp_gap;
	int held[$];
	logic sent_ops[$];

	qta_if #(.T(req_word_t)) req_ch (clk);
	qta_if #(.T(rsp_word_t)) rsp_ch (clk);

	quadtree_tile_allocator_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch.sink),
		.rsp(rsp_ch.source)
	);

	qta_alloc_checker i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_ch.valid),
		.req_ready(req_ch.ready),
		.req_data(req_ch.data),
		.rsp_valid(rsp_ch.valid),
		.rsp_ready(rsp_ch.ready),
		.rsp_data(rsp_ch.data),
		.fail_count(fail_count),
		.pending(pending)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!stall_on || r < 70)
			return 0;
		if (r < 96)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Response side stalls at random; the tracker keeps handles of live tiles.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			rsp_gap <= 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (sent_ops.pop_front() == OP_ALLOC && rsp_ch.data.status == ST_OK) begin
					held.insert(held.size(), int'(rsp_ch.data.tile_handle));
					n_ok_alloc++;
				end
			end
			if (rsp_gap > 0) begin
				rsp_gap <= rsp_gap - 1;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
				rsp_gap <= pick_gap();
			end
		end
	end

	task automatic send_word(logic op, int lvl, int h);
		int gap;
		req_ch.valid <= 1'b1;
		req_ch.data <= '{op: op, size_level: lvl[LW-1:0], handle: h[HW-1:0]};
		do
			@(posedge clk);
		while (!req_ch.ready);
		sent_ops.insert(sent_ops.size(), op);
		if (op == OP_ALLOC)
			n_alloc++;
		else
			n_free++;
		gap = pick_gap();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0 || sent_ops.size() != 0)
			@(posedge clk);
	endtask

	task automatic free_held();
		int idx, h;
		idx = $urandom_range(0, held.size() - 1);
		h = held[idx];
		held.delete(idx);
		send_word(OP_FREE, $urandom_range(0, 7), h);
	endtask

	task automatic alloc_random();
		int r;
		r = $urandom_range(0, 99);
		if (r < 3)
			send_word(OP_ALLOC, $urandom_range(6, 7), $urandom_range(0, 2047));
		else if (r < 10)
			send_word(OP_ALLOC, $urandom_range(0, 1), $urandom_range(0, 2047));
		else if (r < 40)
			send_word(OP_ALLOC, $urandom_range(2, 3), $urandom_range(0, 2047));
		else
			send_word(OP_ALLOC, $urandom_range(4, 5), $urandom_range(0, 2047));
	endtask

	initial begin
		int r;
		n_alloc = 0;
		n_free = 0;
		stall_on = 0;
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.data <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Whole atlas, full atlas, bad frees and out-of-range handles.
		send_word(OP_ALLOC, 0, 0);
		send_word(OP_ALLOC, 5, 2047);
		send_word(OP_FREE, 0, 2047);
		send_word(OP_FREE, 0, 1365);
		drain();
		send_word(OP_FREE, 7, 0);
		send_word(OP_FREE, 0, 0);
		send_word(OP_FREE, 0, 1364);
		for (int l = 1; l <= 7; l++)
			send_word(OP_ALLOC, l, 0);
		send_word(OP_ALLOC, 5, 1364);
		drain();
		while (held.size() != 0)
			free_held();
		drain();
		send_word(OP_ALLOC, 5, 0);
		send_word(OP_ALLOC, 1, 0);
		drain();
		free_held();
		free_held();
		drain();

		stall_on = 1;
		for (int i = 0; i < 1125; i++) begin
			if (i % 300 == 150) begin
				stall_on = ~stall_on;
				drain();
			end
			r = $urandom_range(0, 99);
			if (r < 6)
				send_word(OP_FREE, $urandom_range(0, 7), $urandom_range(0, 2047));
			else if (r < 42 && held.size() != 0)
				free_held();
			else
				alloc_random();
		end
		drain();
		repeat (200) @(posedge clk);

		$display("Covered %0d allocate and %0d free requests, %0d tiles placed.",
			n_alloc, n_free, n_ok_alloc);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
